/* rtl/rgbc_pkg.sv */
// ----------------------------------------------------------------------------
// rgbc_pkg
// Shared types and constants of the 3x3 RGB convolution block.
// ----------------------------------------------------------------------------
package rgbc_pkg;

	localparam int MAX_WIDTH      = 2048;
	localparam int COL_BITS       = $clog2(MAX_WIDTH);
	localparam int WIDTH_BITS     = 12;
	localparam int ROW_BITS       = 16;
	localparam int COEF_FRAC_BITS = 8;
	localparam int COEF_BITS      = 4 + COEF_FRAC_BITS;
	localparam int COL_REG_BITS   = 3 * COEF_BITS;
	localparam int PIX_BITS       = 24;
	localparam int TAPS           = 9;
	// 9-bit signed pixel times coefficient, plus growth for nine terms
	localparam int PROD_BITS      = 9 + COEF_BITS;
	localparam int SUM_BITS       = PROD_BITS + 4;

	localparam int APB_DATA_BITS  = 64;
	localparam int APB_ADDR_BITS  = 6;

	localparam logic [WIDTH_BITS-1:0]   WIDTH_RESET  = WIDTH_BITS'(640);
	localparam logic [ROW_BITS-1:0]     HEIGHT_RESET = ROW_BITS'(480);
	localparam logic [COL_REG_BITS-1:0] COEF_RESET   = 36'h01A01A01A;

	typedef enum logic [2:0] {
		REG_WIDTH    = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_COEF_L   = 3'd2,
		REG_COEF_M   = 3'd3,
		REG_COEF_R   = 3'd4
	} reg_idx_t;

	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef logic [PIX_BITS-1:0]         pix_word_t;

	typedef struct packed {
		logic [7:0] ch0;
		logic [7:0] ch1;
		logic [7:0] ch2;
	} pix_t;

	typedef struct packed {
		logic [7:0]          out_ch0;
		logic [7:0]          out_ch1;
		logic [7:0]          out_ch2;
		logic [ROW_BITS-1:0] out_row;
		logic [COL_BITS-1:0] out_col;
	} res_t;

	typedef struct packed {
		logic [WIDTH_BITS-1:0]             width;
		logic [ROW_BITS-1:0]               height;
		logic [2:0][COL_REG_BITS-1:0]      coef;   // [0] left column
	} cfg_t;

endpackage

/* rtl/rgbc_ram.sv */
// ----------------------------------------------------------------------------
// rgbc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rgbc_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read returns the old word when both ports hit the same address
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/rgbc_regs.sv */
// ----------------------------------------------------------------------------
// rgbc_regs
// APB register file: frame size and the three coefficient columns.
// ----------------------------------------------------------------------------
module rgbc_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rgbc_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [rgbc_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [rgbc_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	output rgbc_pkg::cfg_t                      cfg
);
	import rgbc_pkg::*;

	reg_idx_t idx;
	logic     wr;
	cfg_t     cfg_q;

	assign idx    = reg_idx_t'(paddr[APB_ADDR_BITS-1:3]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width   <= WIDTH_RESET;
			cfg_q.height  <= HEIGHT_RESET;
			cfg_q.coef[0] <= COEF_RESET;
			cfg_q.coef[1] <= COEF_RESET;
			cfg_q.coef[2] <= COEF_RESET;
		end else if (wr) begin
			case (idx)
				REG_WIDTH:  cfg_q.width   <= pwdata[WIDTH_BITS-1:0];
				REG_HEIGHT: cfg_q.height  <= pwdata[ROW_BITS-1:0];
				REG_COEF_L: cfg_q.coef[0] <= pwdata[COL_REG_BITS-1:0];
				REG_COEF_M: cfg_q.coef[1] <= pwdata[COL_REG_BITS-1:0];
				REG_COEF_R: cfg_q.coef[2] <= pwdata[COL_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH:  prdata = APB_DATA_BITS'(cfg_q.width);
			REG_HEIGHT: prdata = APB_DATA_BITS'(cfg_q.height);
			REG_COEF_L: prdata = APB_DATA_BITS'(cfg_q.coef[0]);
			REG_COEF_M: prdata = APB_DATA_BITS'(cfg_q.coef[1]);
			REG_COEF_R: prdata = APB_DATA_BITS'(cfg_q.coef[2]);
			default:    prdata = '0;
		endcase
	end

endmodule

/* rtl/rgbc_mac.sv */
// ----------------------------------------------------------------------------
// rgbc_mac
// Nine-tap multiply-accumulate for one channel, shift and clamp to a byte.
// ----------------------------------------------------------------------------
module rgbc_mac (
	input  logic [rgbc_pkg::TAPS-1:0][7:0]  px,
	input  rgbc_pkg::coef_t [rgbc_pkg::TAPS-1:0] coef,
	output logic [7:0]                      y
);
	import rgbc_pkg::*;

	logic signed [PROD_BITS-1:0] prod [TAPS];
	logic signed [SUM_BITS-1:0]  ext  [TAPS];
	logic signed [SUM_BITS-1:0]  sum;

	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			prod[k] = $signed({1'b0, px[k]}) * $signed(coef[k]);
			ext[k]  = SUM_BITS'(prod[k]);
		end
	end

	// balanced adder tree
	assign sum = ((ext[0] + ext[1]) + (ext[2] + ext[3]))
	           + ((ext[4] + ext[5]) + (ext[6] + ext[7])) + ext[8];

	always_comb begin
		if (sum[SUM_BITS-1]) begin
			y = 8'd0;
		end else if (|sum[SUM_BITS-2:COEF_FRAC_BITS+8]) begin
			y = 8'd255;
		end else begin
			y = sum[COEF_FRAC_BITS +: 8];
		end
	end

endmodule

/* rtl/rgb_3x3_convolution_top.sv */
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_top
// Streaming 3x3 convolution on 8-bit BGR pixels with two line stores.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock while pix_stall is low, with
// no gaps required. Each pixel transfer is registered together with the two
// line-store words of its column (read in the transfer cycle), the nine-tap
// filter runs in the next cycle, and the result enters the output register
// when stage 1 moves on, after the transfer of the pixel that completes its
// window. Throughput is one pixel per clock while pix_stall is low, set by
// the single pass through the three nine-tap MAC units and one read plus one
// write per line store per cycle. Border pixels give no result. The output
// register lets the block keep taking pixels while a result waits, as long
// as the next pixel produces no result. Line stores are not cleared after
// reset; every column is written during the first two rows. Registers sit
// on a 64-bit APB port at byte address 8*i: width, height and the left,
// middle and right coefficient columns (signed Q4.8 per tap).
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rgbc_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [rgbc_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [rgbc_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  rgbc_pkg::pix_t                      pix,
	output logic                                res_valid,
	input  logic                                res_stall,
	output rgbc_pkg::res_t                      res
);
	import rgbc_pkg::*;

	cfg_t cfg;

	rgbc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// position of the next pixel
	logic [COL_BITS-1:0]   col_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [WIDTH_BITS-1:0] width_eff;
	logic [WIDTH_BITS-1:0] col_inc;
	logic [ROW_BITS:0]     row_inc;

	// stage 1: registered pixel and its line-store words
	logic                  valid_s1;
	pix_word_t             pix_s1;
	logic [COL_BITS-1:0]   col_s1;
	logic [ROW_BITS-1:0]   row_s1;
	pix_word_t             up_rd, lo_rd;
	logic                  fwd_q;
	pix_word_t             fwd_up_q, fwd_lo_q;
	pix_word_t             above, center;
	pix_word_t             win_q [6];

	// stage 2: result register
	logic                  valid_s2;
	res_t                  res_s2;

	logic                  pix_xfer, res_xfer, adv_s1, produce;
	pix_word_t             taps [TAPS];
	logic [TAPS-1:0][7:0]  px [3];
	coef_t [TAPS-1:0]      coefs;
	logic [7:0]            y [3];

	assign pix_xfer  = pix_valid && !pix_stall;
	assign res_xfer  = valid_s2 && !res_stall;
	assign produce   = (row_s1 >= ROW_BITS'(2)) && (col_s1 >= COL_BITS'(2));
	assign adv_s1    = valid_s1 && (!produce || !valid_s2 || !res_stall);
	assign pix_stall = valid_s1 && !adv_s1;

	assign width_eff = (cfg.width > WIDTH_BITS'(MAX_WIDTH)) ? WIDTH_BITS'(MAX_WIDTH)
	                                                        : cfg.width;
	assign col_inc   = WIDTH_BITS'(col_q) + WIDTH_BITS'(1);
	assign row_inc   = (ROW_BITS+1)'(row_q) + (ROW_BITS+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_xfer) begin
			if (col_inc >= width_eff) begin
				col_q <= '0;
				row_q <= (row_inc >= (ROW_BITS+1)'(cfg.height)) ? '0
				                                               : row_inc[ROW_BITS-1:0];
			end else begin
				col_q <= col_inc[COL_BITS-1:0];
			end
		end
	end

	// line stores: read at the transfer, written when stage 1 moves on
	rgbc_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_BITS)) u_store_upper (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata (center),
		.re    (pix_xfer),
		.raddr (col_q),
		.rdata (up_rd)
	);

	rgbc_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_BITS)) u_store_lower (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata (pix_s1),
		.re    (pix_xfer),
		.raddr (col_q),
		.rdata (lo_rd)
	);

	// a one-column frame reads the word being written in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (pix_xfer) begin
			fwd_q <= adv_s1 && (col_q == col_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (pix_xfer) begin
			fwd_up_q <= center;
			fwd_lo_q <= pix_s1;
		end
	end

	assign above  = fwd_q ? fwd_up_q : up_rd;
	assign center = fwd_q ? fwd_lo_q : lo_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_xfer) begin
			pix_s1 <= {pix.ch2, pix.ch1, pix.ch0};
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= above;
			win_q[4] <= center;
			win_q[5] <= pix_s1;
		end
	end

	// tap k = column*3 + row within column, left column oldest
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			taps[k] = win_q[k];
		end
		taps[6] = above;
		taps[7] = center;
		taps[8] = pix_s1;
		for (int k = 0; k < TAPS; k++) begin
			coefs[k] = coef_t'(cfg.coef[k / 3][(k % 3) * COEF_BITS +: COEF_BITS]);
			for (int c = 0; c < 3; c++) begin
				px[c][k] = taps[k][8*c +: 8];
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_mac
		rgbc_mac u_mac (
			.px   (px[c]),
			.coef (coefs),
			.y    (y[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && produce) begin
			valid_s2 <= 1'b1;
		end else if (res_xfer) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && produce) begin
			res_s2.out_ch0 <= y[0];
			res_s2.out_ch1 <= y[1];
			res_s2.out_ch2 <= y[2];
			res_s2.out_row <= row_s1 - ROW_BITS'(1);
			res_s2.out_col <= col_s1 - COL_BITS'(1);
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

/* rtl/rgbc_checker.sv */
// ----------------------------------------------------------------------------
// rgbc_checker
// Port-level checks of the convolution block, bound to the top level.
// ----------------------------------------------------------------------------
module rgbc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                psel,
	input logic                                penable,
	input logic                                pwrite,
	input logic [rgbc_pkg::APB_ADDR_BITS-1:0]  paddr,
	input logic [rgbc_pkg::APB_DATA_BITS-1:0]  pwdata,
	input logic [rgbc_pkg::APB_DATA_BITS-1:0]  prdata,
	input logic                                pready,
	input logic                                pix_valid,
	input logic                                pix_stall,
	input rgbc_pkg::pix_t                      pix,
	input logic                                res_valid,
	input logic                                res_stall,
	input rgbc_pkg::res_t                      res
);
	import rgbc_pkg::*;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// results never come from the top row or the left column
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.out_row != '0) && (res.out_col != '0))
		else $error("result for a border pixel");

	// a fresh result follows a pixel transfer through the stage-1 and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(pix_valid && !pix_stall, 2))
		else $error("result without a pixel transfer");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("APB access not ready");

endmodule

bind rgb_3x3_convolution_top rgbc_checker u_rgbc_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Pixel stream test of the 3x3 RGB convolution block. A queue-fed driver
// sends raster frames under several widths, heights and coefficient sets. A
// monitor predicts every filtered pixel from its own line stores and window
// and checks each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import rgbc_pkg::*;

	localparam int TIMEOUT_CYCLES = 600000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int PHASE_PIXELS   = 270;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     pix_valid = 1'b0;
	logic                     pix_stall;
	pix_t                     pix = '0;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	res_t                     res;

	rgb_3x3_convolution_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// pending pixels and expected filtered pixels
	pix_t pixel_q [$];
	res_t filtered_q [$];

	// shadow of the block: configuration, line stores, window, counters
	logic [WIDTH_BITS-1:0]   cfg_width = WIDTH_RESET;
	logic [ROW_BITS-1:0]     cfg_height = HEIGHT_RESET;
	logic [COL_REG_BITS-1:0] cfg_coef [3] = '{COEF_RESET, COEF_RESET, COEF_RESET};
	pix_t                    line_up [MAX_WIDTH];
	pix_t                    line_lo [MAX_WIDTH];
	pix_t                    win_cols [6];
	logic [ROW_BITS-1:0]     row_cnt = '0;
	logic [COL_BITS-1:0]     col_cnt = '0;

	int   snd_idle_pct = 28;
	int   rcv_idle_pct = 56;
	logic pix_fire = 1'b0;
	int   n_err = 0;
	int   cycle_cnt = 0;
	res_t exp_res;

	function automatic logic [COL_REG_BITS-1:0] pack_col(int above, int center, int below);
		logic [COEF_BITS-1:0] a, c, b;
		a = above[COEF_BITS-1:0];
		c = center[COEF_BITS-1:0];
		b = below[COEF_BITS-1:0];
		return {b, c, a};
	endfunction

	// nine taps, column-major (left column first, above/center/below)
	function automatic logic [7:0] filter_channel(pix_t w [9], int ch);
		int                   sum, p, k;
		coef_t                cv;
		int                   cf;
		sum = 0;
		for (k = 0; k < TAPS; k++) begin
			cv = coef_t'(cfg_coef[k / 3][(k % 3) * COEF_BITS +: COEF_BITS]);
			cf = cv;
			case (ch)
				0: p = w[k].ch0;
				1: p = w[k].ch1;
				default: p = w[k].ch2;
			endcase
			sum += p * cf;
		end
		if (sum < 0)
			return 8'd0;
		sum = sum >>> COEF_FRAC_BITS;
		return (sum > 255) ? 8'd255 : sum[7:0];
	endfunction

	task automatic convolve_pixel(pix_t px);
		pix_t w [9];
		res_t r;
		int   i, cn, rn, ew;
		for (i = 0; i < 6; i++)
			w[i] = win_cols[i];
		w[6] = line_up[col_cnt];
		w[7] = line_lo[col_cnt];
		w[8] = px;
		if (row_cnt >= 2 && col_cnt >= 2) begin
			r.out_ch0 = filter_channel(w, 0);
			r.out_ch1 = filter_channel(w, 1);
			r.out_ch2 = filter_channel(w, 2);
			r.out_row = row_cnt - 1'b1;
			r.out_col = col_cnt - 1'b1;
			filtered_q.push_back(r);
		end
		for (i = 0; i < 6; i++)
			win_cols[i] = w[i + 3];
		line_up[col_cnt] = w[7];
		line_lo[col_cnt] = px;
		ew = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
		cn = int'(col_cnt) + 1;
		rn = int'(row_cnt) + 1;
		if (cn >= ew) begin
			col_cnt = '0;
			row_cnt = (rn >= cfg_height) ? '0 : rn[ROW_BITS-1:0];
		end else begin
			col_cnt = cn[COL_BITS-1:0];
		end
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_err++;
		end
	endtask

	// driver: new pixel only when the line is empty or the last one was taken; random result stall
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			res_stall <= 1'b0;
		end else begin
			if (!pix_valid || pix_fire) begin
				if (pixel_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					pix       <= pixel_q.pop_front();
					pix_valid <= 1'b1;
				end else begin
					pix_valid <= 1'b0;
				end
			end
			res_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// monitor: predict on pixel transfers, check on result transfers
	always @(posedge clk) begin
		pix_fire = arst_n && pix_valid && !pix_stall;
		if (pix_fire)
			convolve_pixel(pix);
		if (arst_n && res_valid && !res_stall) begin
			if (filtered_q.size() == 0) begin
				$error("result with nothing expected: row %0d col %0d",
					res.out_row, res.out_col);
				n_err++;
			end else begin
				exp_res = filtered_q.pop_front();
				check_field("out_ch0", exp_res.out_ch0, res.out_ch0);
				check_field("out_ch1", exp_res.out_ch1, res.out_ch1);
				check_field("out_ch2", exp_res.out_ch2, res.out_ch2);
				check_field("out_row", exp_res.out_row, res.out_row);
				check_field("out_col", exp_res.out_col, res.out_col);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= TIMEOUT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// write, then read back the same register
	task automatic cfg_write(reg_idx_t idx, logic [APB_DATA_BITS-1:0] val);
		logic [APB_DATA_BITS-1:0] rd, want;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = APB_ADDR_BITS'({idx, 3'b000});
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		case (idx)
			REG_WIDTH: begin
				cfg_width = val[WIDTH_BITS-1:0];
				want = APB_DATA_BITS'(cfg_width);
			end
			REG_HEIGHT: begin
				cfg_height = val[ROW_BITS-1:0];
				want = APB_DATA_BITS'(cfg_height);
			end
			default: begin
				cfg_coef[idx - REG_COEF_L] = val[COL_REG_BITS-1:0];
				want = APB_DATA_BITS'(val[COL_REG_BITS-1:0]);
			end
		endcase
		if (rd !== want) begin
			$error("register %s readback: expected %0h, got %0h", idx.name(), want, rd);
			n_err++;
		end
	endtask

	// block idle: nothing queued, nothing in flight, every result back
	task automatic wait_idle();
		while (pixel_q.size() != 0 || pix_valid || filtered_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic pix_t rand_pix(bit all_max);
		pix_t p;
		case (all_max ? 1 : $urandom_range(7))
			0: p = '0;
			1: p = '1;
			2: p = {{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
				{8{1'($urandom_range(1))}}};
			default: p = pix_t'($urandom);
		endcase
		return p;
	endfunction

	task automatic queue_pixels(int count, bit all_max);
		repeat (count) pixel_q.push_back(rand_pix(all_max));
	endtask

	function automatic int frame_len();
		int ew, eh;
		ew = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
		eh = (cfg_height == 0) ? 1 : cfg_height;
		return ew * eh;
	endfunction

	function automatic logic [COL_REG_BITS-1:0] rand_kernel_col();
		if ($urandom_range(9) == 0)
			return COL_REG_BITS'({$urandom, $urandom});
		return pack_col(int'($urandom_range(120)) - 40, int'($urandom_range(120)) - 40,
			int'($urandom_range(120)) - 40);
	endfunction

	initial begin
		int  ph, sent, len, half;
		bit  split;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(posedge clk);

		// smallest frame with an interior pixel, with the reset coefficients
		cfg_write(REG_WIDTH, 3);
		cfg_write(REG_HEIGHT, 3);
		queue_pixels(9, 1'b1);
		wait_idle();
		// largest positive taps: saturates high
		cfg_write(REG_COEF_L, pack_col(2047, 2047, 2047));
		cfg_write(REG_COEF_M, pack_col(2047, 2047, 2047));
		cfg_write(REG_COEF_R, pack_col(2047, 2047, 2047));
		queue_pixels(9, 1'b0);
		wait_idle();
		// most negative taps: clamps to zero
		cfg_write(REG_COEF_L, pack_col(-2048, -2048, -2048));
		cfg_write(REG_COEF_M, pack_col(-2048, -2048, -2048));
		cfg_write(REG_COEF_R, pack_col(-2048, -2048, -2048));
		queue_pixels(9, 1'b0);
		wait_idle();
		// identity kernel passes the center pixel through
		cfg_write(REG_COEF_L, 0);
		cfg_write(REG_COEF_M, pack_col(0, 256, 0));
		cfg_write(REG_COEF_R, 0);
		queue_pixels(9, 1'b0);
		wait_idle();
		// frames too small to have an interior pixel
		cfg_write(REG_WIDTH, 1);
		queue_pixels(frame_len(), 1'b0);
		wait_idle();
		cfg_write(REG_WIDTH, 0);
		cfg_write(REG_HEIGHT, 0);
		queue_pixels(frame_len(), 1'b0);
		wait_idle();
		cfg_write(REG_WIDTH, 2);
		cfg_write(REG_HEIGHT, 3);
		queue_pixels(frame_len(), 1'b0);
		wait_idle();
		cfg_write(REG_WIDTH, 3);
		cfg_write(REG_HEIGHT, 2);
		queue_pixels(frame_len(), 1'b0);
		wait_idle();
		// tallest frame, cut short by a smaller height mid-frame
		cfg_write(REG_HEIGHT, 16'hFFFF);
		queue_pixels(12, 1'b0);
		wait_idle();
		cfg_write(REG_HEIGHT, 2);
		queue_pixels(3, 1'b0);
		wait_idle();

		for (ph = 0; ph < 3; ph++) begin
			snd_idle_pct = (ph == 0) ? 28 : ((ph == 1) ? 56 : 0);
			rcv_idle_pct = (ph == 0) ? 56 : ((ph == 1) ? 28 : 0);
			sent = 0;
			while (sent < PHASE_PIXELS) begin
				if (sent == 0 || $urandom_range(1)) begin
					wait_idle();
					cfg_write(REG_WIDTH, ($urandom_range(4) == 0) ?
						$urandom_range(64, 13) : $urandom_range(12, 3));
					cfg_write(REG_HEIGHT, $urandom_range(7, 3));
					if (sent == 0 || $urandom_range(1)) cfg_write(REG_COEF_L, rand_kernel_col());
					if (sent == 0 || $urandom_range(1)) cfg_write(REG_COEF_M, rand_kernel_col());
					if (sent == 0 || $urandom_range(1)) cfg_write(REG_COEF_R, rand_kernel_col());
				end
				len   = frame_len();
				split = (ph == 1 && sent == 0) || ($urandom_range(7) == 0);
				if (split) begin
					// stop mid-frame until every result is back
					half = len / 2;
					queue_pixels(half, 1'b0);
					wait_idle();
					queue_pixels(len - half, 1'b0);
				end else begin
					queue_pixels(len, 1'b0);
				end
				sent += len;
			end
		end

		// width beyond the line store depth is kept as written
		wait_idle();
		cfg_write(REG_WIDTH, 12'hFFF);

		if (n_err == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* rgb_3x3_convolution_top.f */
rtl/rgbc_pkg.sv
rtl/rgbc_ram.sv
rtl/rgbc_regs.sv
rtl/rgbc_mac.sv
rtl/rgb_3x3_convolution_top.sv
rtl/rgbc_checker.sv
dv/testbench.sv
